/* design/gpg_pkg.sv */
package gpg_pkg;

  // Input and arithmetic widths.
  localparam int UB      = 16;              // uniform sample width
  localparam int NFB     = 16;              // fraction bits of a deviate
  localparam int FB      = 2 * (UB - 1);    // fraction bits of W
  localparam int WI_W    = FB;              // W after the range check
  localparam int LF      = 30;              // fraction bits of the log domain
  localparam int YW      = LF + 1;          // normalized W, Q1.30
  localparam int E_W     = $clog2(FB + 1);  // exponent of W
  localparam int NL_W    = LF + E_W;        // -log2 W in Q.30

  localparam int LN_W    = 24;
  localparam logic [LN_W-1:0] LN2_Q24 = 24'd11629080;
  localparam int LN_SH   = 23;
  localparam int V_W     = NL_W + LN_W - LN_SH;

  // Long division of V << 26 by y >> 14.
  localparam int DIV_SH  = 26;
  localparam int DVS_SH  = 14;
  localparam int DVS_W   = YW - DVS_SH;
  localparam int DV_W    = V_W + DIV_SH;
  localparam int QW      = DV_W - (DVS_W - 1);
  localparam int DIV_ST  = QW / 2;

  // Square root of the quotient.
  localparam int S_W     = QW + 1;
  localparam int SQ_W    = (S_W + 1) / 2;
  localparam int SV_W    = 2 * SQ_W;
  localparam int SQ_ST   = SQ_W / 2;
  localparam int SR_W    = SQ_W + 2;

  // Deviate and placement.
  localparam int P_W     = UB + SQ_W;
  localparam int SH_BASE = 20 + UB - 1 - NFB;
  localparam int XM_W    = NFB + 4;
  localparam logic [XM_W-1:0] LIM = XM_W'(1) << (NFB + 3);
  localparam int CW      = 32;
  localparam int PP_W    = CW + XM_W;
  localparam int POS_W   = 33;

  localparam int IN_TW   = ((2 * UB + 7) / 8) * 8;
  localparam int OUT_TW  = ((POS_W + 7) / 8) * 8;

  localparam logic [1:0] CFG_AREA   = 2'd0;
  localparam logic [1:0] CFG_CENTER = 2'd1;
  localparam logic [1:0] CFG_SPREAD = 2'd2;

  typedef struct packed {
    logic [UB-1:0]    ma;
    logic [UB-1:0]    mb;
    logic             na;
    logic             nb;
    logic [E_W-1:0]   e;
    logic [DVS_W-1:0] ydv;
  } sb_t;

  // One squaring step of the log2 fraction search: {bit, new y}.
  function automatic logic [YW:0] log_step(input logic [YW-1:0] y);
    logic [2*YW-1:0] sq;
    logic [YW:0]     t;
    sq = y * y;
    t  = sq[2*YW-1:LF];
    if (t[YW]) begin
      return {1'b1, t[YW:1]};
    end
    return {1'b0, t[YW-1:0]};
  endfunction

  // Two restoring division steps: {remainder, dividend/quotient shift word}.
  function automatic logic [DVS_W+QW-1:0] div_step(input logic [DVS_W-1:0] rem,
                                                   input logic [QW-1:0]    rq,
                                                   input logic [DVS_W-1:0] d);
    logic [DVS_W:0] t;
    logic [DVS_W-1:0] r;
    logic [QW-1:0]  q;
    r = rem;
    q = rq;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[QW-1]};
      q = {q[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        q[0] = 1'b1;
      end
      r = t[DVS_W-1:0];
    end
    return {r, q};
  endfunction

  // Two digit-by-digit square root steps: {remainder, root, radicand shift word}.
  function automatic logic [SR_W+SQ_W+SV_W-1:0] sqrt_step(input logic [SR_W-1:0] rem,
                                                          input logic [SQ_W-1:0] root,
                                                          input logic [SV_W-1:0] sv);
    logic [SR_W+1:0] t;
    logic [SR_W+1:0] tr;
    logic [SR_W-1:0] r;
    logic [SQ_W-1:0] q;
    logic [SV_W-1:0] s;
    r = rem;
    q = root;
    s = sv;
    for (int i = 0; i < 2; i++) begin
      t  = {r, s[SV_W-1:SV_W-2]};
      tr = (SR_W + 2)'({q, 2'b01});
      s  = {s[SV_W-3:0], 2'b00};
      if (t >= tr) begin
        t = t - tr;
        q = {q[SQ_W-2:0], 1'b1};
      end else begin
        q = {q[SQ_W-2:0], 1'b0};
      end
      r = t[SR_W-1:0];
    end
    return {r, q, s};
  endfunction

  // Scales |u|*mult to a deviate magnitude and saturates it: {negative, magnitude}.
  function automatic logic [XM_W:0] saturate(input logic [P_W-1:0] p,
                                             input logic           neg,
                                             input logic [E_W-1:0] e);
    logic [P_W-1:0] v;
    logic [XM_W-1:0] m;
    logic [E_W-1:0] sh;
    sh = E_W'(SH_BASE) - (e >> 1);
    v  = p >> sh;
    if (!neg && v >= P_W'(LIM)) begin
      m = LIM - XM_W'(1);
    end else if (neg && v > P_W'(LIM)) begin
      m = LIM;
    end else begin
      m = v[XM_W-1:0];
    end
    return {neg && (m != '0), m};
  endfunction

  // center + spread*x truncated toward zero, kept only inside (0, area).
  function automatic logic [POS_W-1:0] place(input logic [PP_W-1:0] q,
                                             input logic            xneg,
                                             input logic [CW-1:0]   center,
                                             input logic [CW-1:0]   area);
    logic [PP_W:0]      c;
    logic [PP_W:0]      s;
    logic [PP_W-NFB:0]  pos;
    logic               bad;
    c   = (PP_W + 1)'({center, {NFB{1'b0}}});
    bad = 1'b0;
    if (!xneg) begin
      s = c + {1'b0, q};
    end else begin
      bad = c < {1'b0, q};
      s   = c - {1'b0, q};
    end
    pos = s[PP_W:NFB];
    if (!bad && pos != '0 && pos < (PP_W - NFB + 1)'(area)) begin
      return pos[POS_W-1:0];
    end
    return '1;
  endfunction

endpackage

/* design/gaussian_position_generator_top.sv */
// Gaussian position generator, fixed-point Marsaglia polar method.
// The in_ channel takes one transaction per pair of signed Q1.15 uniform
// samples. A pair with W = u1^2 + u2^2 zero or at least one is dropped and
// produces nothing. An accepted pair produces two out_ transactions: the
// position drawn from uniform_a first, then the one from uniform_b with
// out_tlast high. A position is -1 when center + spread*x falls outside
// (0, area).
// A pair is accepted in every cycle in which the pipeline is not held. The
// pipeline has about 73 register stages: a squaring unit per bit of the
// log2 fraction (30), a long division at two quotient bits per stage (23),
// a square root at two root bits per stage (12) and the multiply, saturate
// and placement stages. The single result port sets the sustained rate: an
// accepted pair gives two results on it, a dropped pair gives none.
// When the receiver stalls, the two-result output buffer fills and the
// whole pipeline holds in place; in_tready falls and nothing is lost.
// Reset clears all stage valid bits, the output buffer count and the area,
// center and spread registers. Write cfg_ only while the block is idle.
module gaussian_position_generator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [gpg_pkg::IN_TW-1:0]  in_tdata,   // uniform_a[15:0], uniform_b[31:16]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [gpg_pkg::OUT_TW-1:0] out_tdata,  // position[32:0], zeros above
  output logic                       out_tlast,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [gpg_pkg::CW-1:0]     cfg_wr_data
);
  import gpg_pkg::*;

  logic [CW-1:0] area_r, center_r, spread_r;

  // Stage 0: magnitudes, W and the range check.
  logic [UB-1:0]  ua, ub, ma, mb;
  logic [2*UB-1:0] wi_full;
  logic           keep, en, load_ok;
  logic [WI_W-1:0] wi0_r;
  sb_t            sb0_r;
  logic           v0_r;

  // Stage 1 and the log stages.
  logic [E_W-1:0] n_top;
  logic [YW-1:0]  y_norm;
  logic [YW-1:0]  ylg_r  [0:LF];
  logic [LF-1:0]  frac_r [0:LF];
  sb_t            sbl_r  [0:LF];
  logic           vl_r   [0:LF];
  logic [YW:0]    lgo    [0:LF-1];

  // Log scaling feeding the divider.
  logic [NL_W-1:0]      nl;
  logic [NL_W+LN_W-1:0] vmul;
  logic [DV_W-1:0]      dvd;

  logic [DVS_W-1:0] drem_r [0:DIV_ST];
  logic [QW-1:0]    drq_r  [0:DIV_ST];
  sb_t              sbd_r  [0:DIV_ST];
  logic             vd_r   [0:DIV_ST];
  logic [DVS_W+QW-1:0] dvo [0:DIV_ST-1];

  logic [S_W-1:0]   s_adj;
  logic             e_odd;
  sb_t              sb_sq;
  logic [SR_W-1:0]  srem_r  [0:SQ_ST];
  logic [SQ_W-1:0]  sroot_r [0:SQ_ST];
  logic [SV_W-1:0]  ssv_r   [0:SQ_ST];
  sb_t              sbs_r   [0:SQ_ST];
  logic             vs_r    [0:SQ_ST];
  logic [SR_W+SQ_W+SV_W-1:0] sqo [0:SQ_ST-1];

  logic [P_W-1:0]  pa_r, pb_r;
  sb_t             sbm_r;
  logic            vm_r;

  logic [XM_W:0]   sat_a, sat_b;
  logic [XM_W-1:0] xa_r, xb_r;
  logic            xna_r, xnb_r, vx_r;

  logic [PP_W-1:0] qa_r, qb_r;
  logic            qna_r, qnb_r, vq_r;

  logic [POS_W-1:0] ob_a_r, ob_b_r;
  logic [1:0]       ocnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r   <= '0;
      center_r <= '0;
      spread_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_AREA:   area_r   <= cfg_wr_data;
        CFG_CENTER: center_r <= cfg_wr_data;
        CFG_SPREAD: spread_r <= cfg_wr_data;
        default:    ;
      endcase
    end
  end

  // The pipeline moves as a whole; it holds only when its last stage has a
  // pair that the output buffer cannot take.
  assign load_ok   = (ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && out_tready);
  assign en        = !vq_r || load_ok;
  assign in_tready = en;

  always_comb begin
    ua      = in_tdata[UB-1:0];
    ub      = in_tdata[2*UB-1:UB];
    ma      = ua[UB-1] ? (~ua + UB'(1)) : ua;
    mb      = ub[UB-1] ? (~ub + UB'(1)) : ub;
    wi_full = (2*UB)'(ma * ma) + (2*UB)'(mb * mb);
    keep    = (wi_full != '0) && (wi_full < ((2*UB)'(1) << FB));
  end

  // Top set bit of W and the shift that brings it to Q1.30.
  always_comb begin
    n_top = '0;
    for (int i = 0; i < WI_W; i++) begin
      if (wi0_r[i]) begin
        n_top = E_W'(i);
      end
    end
    y_norm = YW'(wi0_r) << (E_W'(LF) - n_top);
  end

  always_comb begin
    for (int k = 0; k < LF; k++) begin
      lgo[k] = log_step(ylg_r[k]);
    end
    nl   = {sbl_r[LF].e, {LF{1'b0}}} - NL_W'(frac_r[LF]);
    vmul = nl * LN2_Q24;
    dvd  = {vmul[NL_W+LN_W-1:LN_SH], {DIV_SH{1'b0}}};
    for (int k = 0; k < DIV_ST; k++) begin
      dvo[k] = div_step(drem_r[k], drq_r[k], sbd_r[k].ydv);
    end
    e_odd = sbd_r[DIV_ST].e[0];
    s_adj = e_odd ? {drq_r[DIV_ST], 1'b0} : {1'b0, drq_r[DIV_ST]};
    // An odd exponent is folded into the radicand so that half of it is whole.
    sb_sq   = sbd_r[DIV_ST];
    sb_sq.e = sbd_r[DIV_ST].e - E_W'(e_odd);
    for (int k = 0; k < SQ_ST; k++) begin
      sqo[k] = sqrt_step(srem_r[k], sroot_r[k], ssv_r[k]);
    end
    sat_a = saturate(pa_r, sbm_r.na, sbm_r.e);
    sat_b = saturate(pb_r, sbm_r.nb, sbm_r.e);
  end

  // Payload stages, no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      wi0_r    <= wi_full[WI_W-1:0];
      sb0_r    <= '{ma: ma, mb: mb, na: ua[UB-1], nb: ub[UB-1], e: '0, ydv: '0};

      ylg_r[0]  <= y_norm;
      frac_r[0] <= '0;
      sbl_r[0]  <= '{ma: sb0_r.ma, mb: sb0_r.mb, na: sb0_r.na, nb: sb0_r.nb,
                     e: E_W'(FB) - n_top, ydv: y_norm[YW-1:DVS_SH]};
      for (int k = 0; k < LF; k++) begin
        ylg_r[k+1]  <= lgo[k][YW-1:0];
        frac_r[k+1] <= frac_r[k] | (LF'(lgo[k][YW]) << (LF - 1 - k));
        sbl_r[k+1]  <= sbl_r[k];
      end

      drem_r[0] <= DVS_W'(dvd[DV_W-1:QW]);
      drq_r[0]  <= dvd[QW-1:0];
      sbd_r[0]  <= sbl_r[LF];
      for (int k = 0; k < DIV_ST; k++) begin
        drem_r[k+1] <= dvo[k][DVS_W+QW-1:QW];
        drq_r[k+1]  <= dvo[k][QW-1:0];
        sbd_r[k+1]  <= sbd_r[k];
      end

      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      ssv_r[0]   <= SV_W'(s_adj);
      sbs_r[0]   <= sb_sq;
      for (int k = 0; k < SQ_ST; k++) begin
        srem_r[k+1]  <= sqo[k][SR_W+SQ_W+SV_W-1:SQ_W+SV_W];
        sroot_r[k+1] <= sqo[k][SQ_W+SV_W-1:SV_W];
        ssv_r[k+1]   <= sqo[k][SV_W-1:0];
        sbs_r[k+1]   <= sbs_r[k];
      end

      pa_r  <= P_W'(sbs_r[SQ_ST].ma * sroot_r[SQ_ST]);
      pb_r  <= P_W'(sbs_r[SQ_ST].mb * sroot_r[SQ_ST]);
      sbm_r <= sbs_r[SQ_ST];

      xa_r  <= sat_a[XM_W-1:0];
      xna_r <= sat_a[XM_W];
      xb_r  <= sat_b[XM_W-1:0];
      xnb_r <= sat_b[XM_W];

      qa_r  <= PP_W'(spread_r * xa_r);
      qb_r  <= PP_W'(spread_r * xb_r);
      qna_r <= xna_r;
      qnb_r <= xnb_r;
    end
    if (en && vq_r) begin
      ob_a_r <= place(qa_r, qna_r, center_r, area_r);
      ob_b_r <= place(qb_r, qnb_r, center_r, area_r);
    end
  end

  // Valid bits and the output buffer count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      for (int k = 0; k <= LF; k++) begin
        vl_r[k] <= 1'b0;
      end
      for (int k = 0; k <= DIV_ST; k++) begin
        vd_r[k] <= 1'b0;
      end
      for (int k = 0; k <= SQ_ST; k++) begin
        vs_r[k] <= 1'b0;
      end
      vm_r   <= 1'b0;
      vx_r   <= 1'b0;
      vq_r   <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (en) begin
        v0_r    <= in_tvalid && keep;
        vl_r[0] <= v0_r;
        for (int k = 0; k < LF; k++) begin
          vl_r[k+1] <= vl_r[k];
        end
        vd_r[0] <= vl_r[LF];
        for (int k = 0; k < DIV_ST; k++) begin
          vd_r[k+1] <= vd_r[k];
        end
        vs_r[0] <= vd_r[DIV_ST];
        for (int k = 0; k < SQ_ST; k++) begin
          vs_r[k+1] <= vs_r[k];
        end
        vm_r <= vs_r[SQ_ST];
        vx_r <= vm_r;
        vq_r <= vx_r;
      end
      if (en && vq_r) begin
        ocnt_r <= 2'd2;
      end else if (out_tvalid && out_tready) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  assign out_tvalid = (ocnt_r != 2'd0);
  assign out_tlast  = (ocnt_r == 2'd1);
  assign out_tdata  = OUT_TW'((ocnt_r == 2'd2) ? ob_a_r : ob_b_r);

`ifndef SYNTHESIS
  a_empty_buffer_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == 2'd0) |-> in_tready)
    else $error("pipeline stalled with an empty output buffer");

  a_first_then_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (ocnt_r == 2'd2)) |=> (ocnt_r == 2'd1))
    else $error("second result of a pair did not follow the first");

  a_rejected_dropped : assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> (wi0_r != '0))
    else $error("a pair with W of zero entered the pipeline");

  a_buffer_count : assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r != 2'd3))
    else $error("output buffer count out of range");
`endif

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpg_pkg::*;

  // The pipeline is about 73 stages deep; a dropped pair leaves no trace in
  // the result queue, so idle checks wait past that depth once the queue is empty.
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [63:0] LN2_FIX = 64'd11629080;
  localparam logic [32:0] OUTSIDE = '1;

  typedef struct {
    logic [32:0] position;
    logic        last;
  } drawn_pos_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_TW-1:0] out_tdata;
  logic              out_tlast;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [CW-1:0]     cfg_wr_data;

  // Our own copy of the three registers, updated with every write.
  logic [31:0] area_q;
  logic [31:0] center_q;
  logic [31:0] spread_q;

  drawn_pos_t pending_pos[$];
  int         error_count;
  int         cycle_count;
  // When set, neither side inserts idle cycles.
  bit         steady;

  gaussian_position_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake must never stall the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 25);
  endfunction

  // The receiver stalls at random, driven away from the sampling edge.
  always @(negedge clk) begin
    out_tready <= !take_break();
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Bit-serial integer square root, floor of sqrt(v).
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // |u| * mult rescaled to Q.16 and clamped to [-8, 8 - 2^-16].
  function automatic void scale_deviate(input logic [63:0] mag, input bit neg,
                                        input logic [63:0] mult, input int half_exp,
                                        output logic [63:0] xmag, output bit xneg);
    logic [63:0] lim;
    logic [63:0] prod;
    logic [63:0] val;
    int          sh;
    lim  = 64'd8 << 16;
    prod = mag * mult;
    sh   = 19 - half_exp;
    if (sh >= 64) begin
      val = 0;
    end else if (sh >= 0) begin
      val = prod >> sh;
    end else begin
      val = (prod >= ((lim + (64'd1 << -sh) - 1) >> -sh)) ? lim : (prod << -sh);
    end
    if (!neg && val >= lim) val = lim - 1;
    if (neg && val > lim) val = lim;
    xmag = val;
    xneg = neg && (val != 0);
  endfunction

  // center + spread*x, truncated toward zero; outside (0, area) reads as -1.
  function automatic logic [32:0] locate_position(input logic [63:0] xmag, input bit xneg);
    logic [63:0] base;
    logic [63:0] offset;
    logic [63:0] pos;
    base   = {16'd0, center_q, 16'd0};
    offset = {32'd0, spread_q} * xmag;
    if (!xneg) begin
      pos = (base + offset) >> 16;
    end else begin
      if (base < offset) return OUTSIDE;
      pos = (base - offset) >> 16;
    end
    if (pos > 0 && pos < {32'd0, area_q}) return pos[32:0];
    return OUTSIDE;
  endfunction

  // Polar-method draw for one uniform pair; queues the two positions it makes,
  // or nothing when W is zero or the pair falls outside the open unit disc.
  function automatic void predict_positions(input logic [15:0] ua, input logic [15:0] ub);
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] w;
    logic [63:0] y;
    logic [63:0] y0;
    logic [63:0] frac;
    logic [63:0] neg_log;
    logic [63:0] ln_term;
    logic [63:0] quot;
    logic [63:0] mult;
    logic [63:0] xm;
    bit          xn;
    int          top;
    int          ex;
    drawn_pos_t  first;
    drawn_pos_t  second;
    mag_a = ua[15] ? {48'd0, 16'(-ua)} : {48'd0, ua};
    mag_b = ub[15] ? {48'd0, 16'(-ub)} : {48'd0, ub};
    if (mag_a == 0 && ua[15]) mag_a = 64'd32768;
    if (mag_b == 0 && ub[15]) mag_b = 64'd32768;
    w = mag_a * mag_a + mag_b * mag_b;
    if (w == 0 || w >= (64'd1 << 30)) return;
    top = 63;
    while (w[top] == 1'b0) top--;
    ex = 30 - top;
    y0 = (top >= 30) ? (w >> (top - 30)) : (w << (30 - top));
    y = y0;
    frac = 0;
    for (int i = 29; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        frac[i] = 1'b1;
      end
    end
    neg_log = (64'(ex) << 30) - frac;
    ln_term = (neg_log * LN2_FIX) >> 23;
    quot    = (ln_term << 26) / (y0 >> 14);
    if (ex % 2 == 1) begin
      quot = quot << 1;
      ex   = ex - 1;
    end
    mult = int_sqrt(quot);
    scale_deviate(mag_a, ua[15], mult, ex / 2, xm, xn);
    first.position = locate_position(xm, xn);
    first.last     = 1'b0;
    scale_deviate(mag_b, ub[15], mult, ex / 2, xm, xn);
    second.position = locate_position(xm, xn);
    second.last     = 1'b1;
    pending_pos.push_back(first);
    pending_pos.push_back(second);
  endfunction

  // Each accepted result is checked against the oldest expected position.
  always @(posedge clk) begin
    drawn_pos_t exp_pos;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pos.size() == 0) begin
        report_mismatch($sformatf("unexpected result position=%h last=%b",
                                  out_tdata[32:0], out_tlast));
      end else begin
        exp_pos = pending_pos.pop_front();
        if (out_tdata[32:0] !== exp_pos.position) begin
          report_mismatch($sformatf("position got %h want %h",
                                    out_tdata[32:0], exp_pos.position));
        end
        if (out_tlast !== exp_pos.last) begin
          report_mismatch($sformatf("last got %b want %b", out_tlast, exp_pos.last));
        end
      end
    end
  end

  // Starts and ends at a falling edge; tvalid stays high across back-to-back
  // transactions and is only lowered by a gap or by the end of the stimulus.
  task automatic send_pair(input logic [15:0] ua, input logic [15:0] ub);
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ub, ua};
    do @(posedge clk); while (!in_tready);
    predict_positions(ua, ub);
    @(negedge clk);
  endtask

  // Waits until the pipeline is empty: no expectation left, then the full
  // pipeline depth for any pair still in flight that will be dropped.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_AREA: begin
        area_q = value;
      end
      CFG_CENTER: begin
        center_q = value;
      end
      CFG_SPREAD: begin
        spread_q = value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_registers(input logic [31:0] area, input logic [31:0] center,
                               input logic [31:0] spread);
    wait_idle();
    write_register(CFG_AREA, area);
    write_register(CFG_CENTER, center);
    write_register(CFG_SPREAD, spread);
  endtask

  // Corners of the unit disc: zero, full-scale negatives, the rim just inside
  // and just outside, tiny magnitudes that give the largest deviates.
  task automatic test_directed_pairs();
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(16'sd0, -16'sd32768);
    send_pair(16'sd100, -16'sd32768);
    send_pair(16'sd32767, 16'sd0);
    send_pair(16'sd0, 16'sd32767);
    send_pair(-16'sd32767, 16'sd0);
    send_pair(16'sd32767, 16'sd1000);
    send_pair(16'sd23170, 16'sd23170);
    send_pair(16'sd23171, 16'sd23171);
    send_pair(-16'sd23170, 16'sd23170);
    send_pair(16'sd1, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(-16'sd1, 16'sd0);
    send_pair(-16'sd1, -16'sd1);
    send_pair(16'sd1, 16'sd1);
    send_pair(16'sd16384, 16'sd0);
    send_pair(16'sd8192, -16'sd8192);
    send_pair(16'sd100, -16'sd200);
    send_pair(-16'sd5000, 16'sd12000);
    send_pair(16'sd30000, -16'sd10000);
  endtask

  function automatic logic [15:0] random_sample();
    logic [15:0] raw;
    raw = 16'($urandom);
    // About one sample in three is shrunk toward zero so that small W and
    // large exponents, where the deviates saturate, come up often.
    if ($urandom_range(0, 2) == 0) raw = 16'($signed(raw) >>> $urandom_range(1, 15));
    return raw;
  endfunction

  task automatic test_random_pairs(input int count);
    for (int i = 0; i < count; i++) begin
      send_pair(random_sample(), random_sample());
    end
  endtask

  // Back-to-back traffic on both sides, then a full stop of the sender until
  // every expected position has come out, then more traffic.
  task automatic test_full_rate(input int count);
    steady = 1'b1;
    test_random_pairs(count);
    steady = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
    test_random_pairs(count / 2);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_AREA;
    cfg_wr_data = '0;
    area_q      = '0;
    center_q    = '0;
    spread_q    = '0;
    error_count = 0;
    steady      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With the reset registers the area is empty, so every position is -1.
    test_directed_pairs();

    set_registers(32'd1000000, 32'd500000, 32'd100000);
    test_directed_pairs();
    test_random_pairs(150);

    // Widest area with a wide spread: the negative tail reaches the lower bound.
    set_registers(32'hFFFF_FFFF, 32'h8000_0000, 32'h1000_0000);
    test_full_rate(100);

    // Zero center: every negative deviate lands at or below zero.
    set_registers(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    test_random_pairs(100);

    // Center at the top with no spread: the center equals the area, so every position is -1.
    set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    test_random_pairs(40);

    set_registers(32'd64, 32'd32, 32'd10);
    test_directed_pairs();
    test_random_pairs(120);

    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
